// ----- src/utf8_stream_decoder_assert.svh -----
// Assertion macros for the UTF-8 stream decoder.
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("u8sd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("u8sd assertion failed");
`else
`define U8SD_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/u8sd_pkg.sv -----
// Package with status codes and range limits for the UTF-8 stream decoder.
package u8sd_pkg;

	localparam int unsigned CpWidth = 31;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_END       = 3'd1,
		ST_TRUNC     = 3'd2,
		ST_BADBYTE   = 3'd3,
		ST_RANGE     = 3'd4,
		ST_LENGTH    = 3'd5,
		ST_SURROGATE = 3'd6
	} status_t;

	// Sequence lengths, counted in bytes including the lead byte.
	localparam logic [2:0] LEN_2 = 3'd2;
	localparam logic [2:0] LEN_3 = 3'd3;
	localparam logic [2:0] LEN_4 = 3'd4;
	localparam logic [2:0] LEN_5 = 3'd5;
	localparam logic [2:0] LEN_6 = 3'd6;

	// Smallest legal value of each form and the upper limits.
	localparam logic [CpWidth-1:0] MIN_2    = 31'h0000_0080;
	localparam logic [CpWidth-1:0] MIN_3    = 31'h0000_0800;
	localparam logic [CpWidth-1:0] MIN_4    = 31'h0001_0000;
	localparam logic [CpWidth-1:0] MIN_5    = 31'h0020_0000;
	localparam logic [CpWidth-1:0] MIN_6    = 31'h0400_0000;
	localparam logic [CpWidth-1:0] MAX_5    = 31'h03FF_FFFF;
	localparam logic [CpWidth-1:0] LIM_UNI  = 31'h0011_0000;
	localparam logic [CpWidth-1:0] SURR_LO  = 31'h0000_D800;
	localparam logic [CpWidth-1:0] SURR_HI  = 31'h0000_DFFF;

endpackage

// ----- src/utf8_stream_decoder.sv -----
// UTF-8 stream decoder: bytes in, code points or error status out.
// A byte passes through the input register and then the result register to m_axis (two register stages).
// Throughput: one item per cycle; the input register and the result register both advance
// every cycle unless the result register holds an untaken result.
// Reset (arst_n low) empties both stages, returns the decoder to idle and sets strict_mode to 1.
// Lead and middle bytes of a sequence produce no result item.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder
	import u8sd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: strict_mode register.
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] end_of_input
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [30:0] code_point, [31] zero fill
	output logic [2:0]  m_axis_tuser    // [2:0] status
);

	// Configuration register.
	logic strict_q;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	// Decoder state: continuation bytes still due, total length and gathered payload.
	logic [2:0]         bytes_left_q;
	logic [2:0]         seq_len_q;
	logic [CpWidth-1:0] partial_q;

	// Result register stage.
	logic               valid_s2;
	logic [CpWidth-1:0] cp_s2;
	status_t            status_s2;

	// Decode of the item in the input register.
	logic               emit;
	logic [CpWidth-1:0] emit_cp;
	status_t            emit_st;
	logic [2:0]         nxt_left;
	logic [2:0]         nxt_len;
	logic [CpWidth-1:0] nxt_part;
	logic [CpWidth-1:0] shifted;
	logic [2:0]         left_dec;
	status_t            fin_st;

	logic out_free;
	logic s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q <= 1'b1;
		end else if (cfg_wr_en) begin
			strict_q <= cfg_wr_data;
		end
	end

	// The result slot is free when empty or being taken this cycle. The item in the
	// input register moves on when it makes no result, or when the slot is free.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign s1_adv        = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			end_s1  <= s_axis_tuser;
		end
	end

	// Payload after taking one more continuation byte, and the count that remains.
	assign shifted  = {partial_q[CpWidth-7:0], byte_s1[5:0]};
	assign left_dec = bytes_left_q - 3'd1;

	// Checks on the completed value, by the length of its form. The four-byte upper
	// limit follows strict_mode as it stands at the final byte.
	always_comb begin
		case (seq_len_q)
			LEN_2: fin_st = (shifted < MIN_2) ? ST_RANGE : ST_OK;
			LEN_3: begin
				if (shifted < MIN_3) begin
					fin_st = ST_RANGE;
				end else if (shifted >= SURR_LO && shifted <= SURR_HI) begin
					fin_st = ST_SURROGATE;
				end else begin
					fin_st = ST_OK;
				end
			end
			LEN_4: begin
				if (shifted < MIN_4 || (strict_q && shifted >= LIM_UNI)) begin
					fin_st = ST_RANGE;
				end else begin
					fin_st = ST_OK;
				end
			end
			LEN_5: fin_st = (shifted < MIN_5 || shifted > MAX_5) ? ST_RANGE : ST_OK;
			LEN_6: fin_st = (shifted < MIN_6) ? ST_RANGE : ST_OK;
			default: fin_st = ST_BADBYTE;
		endcase
	end

	// Next decoder state and the result, if any. Every result returns the decoder to idle.
	always_comb begin
		emit     = 1'b0;
		emit_cp  = '0;
		emit_st  = ST_OK;
		nxt_left = '0;
		nxt_len  = '0;
		nxt_part = '0;
		if (bytes_left_q == 3'd0) begin
			if (end_s1) begin
				emit    = 1'b1;
				emit_st = ST_END;
			end else if (!byte_s1[7]) begin
				// Plain ASCII byte.
				emit    = 1'b1;
				emit_cp = {{(CpWidth-8){1'b0}}, byte_s1};
			end else if (byte_s1 >= 8'hC2 && byte_s1 <= 8'hDF) begin
				nxt_len  = LEN_2;
				nxt_left = 3'd1;
				nxt_part = {{(CpWidth-5){1'b0}}, byte_s1[4:0]};
			end else if (byte_s1[7:4] == 4'hE) begin
				nxt_len  = LEN_3;
				nxt_left = 3'd2;
				nxt_part = {{(CpWidth-4){1'b0}}, byte_s1[3:0]};
			end else if (byte_s1[7:3] == 5'b11110) begin
				nxt_len  = LEN_4;
				nxt_left = 3'd3;
				nxt_part = {{(CpWidth-3){1'b0}}, byte_s1[2:0]};
			end else if (byte_s1 >= 8'hF8 && byte_s1 <= 8'hFD) begin
				// Legacy five- and six-byte leads.
				if (strict_q) begin
					emit    = 1'b1;
					emit_st = ST_LENGTH;
				end else if (byte_s1 <= 8'hFB) begin
					nxt_len  = LEN_5;
					nxt_left = 3'd4;
					nxt_part = {{(CpWidth-2){1'b0}}, byte_s1[1:0]};
				end else begin
					nxt_len  = LEN_6;
					nxt_left = 3'd5;
					nxt_part = {{(CpWidth-1){1'b0}}, byte_s1[0]};
				end
			end else begin
				// Stray continuation byte, overlong two-byte lead, FE or FF.
				emit    = 1'b1;
				emit_st = ST_BADBYTE;
			end
		end else begin
			if (end_s1) begin
				emit    = 1'b1;
				emit_st = ST_TRUNC;
			end else if (byte_s1[7:6] != 2'b10) begin
				emit    = 1'b1;
				emit_st = ST_BADBYTE;
			end else if (left_dec != 3'd0) begin
				nxt_len  = seq_len_q;
				nxt_left = left_dec;
				nxt_part = shifted;
			end else begin
				emit    = 1'b1;
				emit_st = fin_st;
				emit_cp = (fin_st == ST_OK) ? shifted : '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			seq_len_q    <= '0;
			partial_q    <= '0;
		end else if (s1_adv) begin
			bytes_left_q <= nxt_left;
			seq_len_q    <= nxt_len;
			partial_q    <= nxt_part;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= s1_adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_adv && emit) begin
			cp_s2     <= emit_cp;
			status_s2 <= emit_st;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {1'b0, cp_s2};
	assign m_axis_tuser  = status_s2;

	// An error or end result never carries a code point.
	`U8SD_ASSERT_IMPLY(a_err_zero_cp, clk, arst_n,
		m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata == 32'd0)
	// While idle, no length or payload is left over from an earlier sequence.
	`U8SD_ASSERT_IMPLY(a_idle_clean, clk, arst_n,
		bytes_left_q == 3'd0, seq_len_q == 3'd0 && partial_q == '0)
	// Within a sequence, fewer continuation bytes remain than its length.
	`U8SD_ASSERT_IMPLY(a_left_below_len, clk, arst_n,
		bytes_left_q != 3'd0, bytes_left_q < seq_len_q)
	// A delivered result leaves the decoder idle.
	`U8SD_ASSERT_NEXT(a_emit_idle, clk, arst_n,
		s1_adv && emit, bytes_left_q == 3'd0)

endmodule
